@@ design/ids_pkg.sv @@
package ids_pkg;

    // Register indexes of the configuration port
    localparam logic [7:0] CFG_RETRY_LIMIT     = 8'd0;
    localparam logic [7:0] CFG_PRECHARGE_TICKS = 8'd1;
    localparam logic [7:0] CFG_MIN_BUS_VOLTAGE = 8'd2;

    // Reset values of the configuration registers
    localparam logic [7:0]  RETRY_LIMIT_RESET     = 8'd100;
    localparam logic [7:0]  PRECHARGE_TICKS_RESET = 8'd150;
    localparam logic [15:0] MIN_BUS_VOLTAGE_RESET = 16'd50;

    // Error register reply that stands for "no reply yet"
    localparam logic [15:0] REPLY_NONE = 16'hDEAD;

    // Sticky error bit positions
    localparam int ERR_BATTERY_LINK = 0;
    localparam int ERR_VDC_LOW      = 1;
    localparam int ERR_INV_COM      = 2;
    localparam int ERR_INV_INTERNAL = 3;
    localparam int ERR_CONTACTOR    = 4;
    localparam int ERR_FRG          = 5;

    // LED patterns per main state
    localparam logic [3:0] LED_NONE    = 4'd0;
    localparam logic [3:0] LED_STARTUP = 4'd1;
    localparam logic [3:0] LED_CHARGED = 4'd2;
    localparam logic [3:0] LED_ENABLE  = 4'd3;
    localparam logic [3:0] LED_READY   = 4'd4;
    localparam logic [3:0] LED_ERROR   = 4'd5;

    typedef struct packed {
        logic [15:0]        bus_voltage;
        logic               reply_valid;
        logic [15:0]        reply_value;
        logic               inverter_faulted;
        logic               contactor_open_seen;
        logic               inverter_ready_pin;
        logic               drive_switch;
        logic signed [15:0] torque_request;
        logic signed [15:0] regen_torque;
        logic               reboot_request;
    } ids_in_t;

    typedef struct packed {
        logic [2:0]         main_mode;
        logic [3:0]         led_pattern;
        logic [5:0]         error_bits;
        logic signed [15:0] torque_command;
        logic               torque_valid;
        logic               read_error_req;
        logic               clear_error_pulse;
        logic               inverter_off;
        logic               contactor_close;
        logic               drive_enable_cmd;
    } ids_out_t;

endpackage

@@ design/ids_if.sv @@
interface ids_in_if;
    import ids_pkg::*;

    logic    valid;
    logic    ready;
    ids_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ids_out_if;
    import ids_pkg::*;

    logic     valid;
    logic     ready;
    ids_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ids_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/inverter_drive_sequencer_core.sv @@
// Inverter drive sequencer: each input word is one control tick and yields exactly one
// result word, computed combinationally from the tick and the sequencer state and held
// in an output register. A tick is taken every cycle as long as the output register is
// empty or its word is taken in the same cycle. Configuration (retry limit, precharge
// ticks, minimum bus voltage) is written through the cfg channel, which is always ready;
// writes to unknown indexes are ignored.
module inverter_drive_sequencer_core (
    input  logic      clk,
    input  logic      rst_n,
    ids_in_if.sink    tick,
    ids_out_if.source result,
    ids_cfg_if.sink   cfg
);
    import ids_pkg::*;

    typedef enum logic [2:0] {
        M_STARTUP = 3'd0,
        M_CHARGED = 3'd1,
        M_ENABLE  = 3'd2,
        M_READY   = 3'd3,
        M_ERROR   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        SP_CHECK_VOLTAGE = 2'd0,
        SP_PRECHARGE     = 2'd1,
        SP_READ_ERROR    = 2'd2,
        SP_CHECK_FAULT   = 2'd3
    } startup_phase_t;

    typedef enum logic [1:0] {
        EP_TURN_ON     = 2'd0,
        EP_READ_ERROR  = 2'd1,
        EP_CHECK_FAULT = 2'd2
    } enable_phase_t;

    // Configuration registers
    logic [7:0]  retry_limit_reg;
    logic [7:0]  precharge_ticks_reg;
    logic [15:0] min_bus_voltage_reg;

    // Sequencer state
    mode_t          main_mode_reg,     main_mode_next;
    startup_phase_t startup_phase_reg, startup_phase_next;
    logic [8:0]     startup_tries_reg, startup_tries_next;
    logic [7:0]     precharge_count_reg, precharge_count_next;
    enable_phase_t  enable_phase_reg,  enable_phase_next;
    logic [7:0]     enable_tries_reg,  enable_tries_next;
    logic [5:0]     fault_bits_reg,    fault_bits_next;
    logic [15:0]    reply_word_reg,    reply_word_next;

    // Output register
    logic     out_valid_reg;
    ids_out_t out_data_reg;
    ids_out_t out_next;

    logic tick_fire;
    logic vdc_low;

    assign tick.ready   = !out_valid_reg || result.ready;
    assign tick_fire    = tick.valid && tick.ready;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    assign vdc_low = tick.data.bus_voltage < min_bus_voltage_reg;

    // Compute next state and the result word for the current tick
    always_comb
    begin
        main_mode_next       = main_mode_reg;
        startup_phase_next   = startup_phase_reg;
        startup_tries_next   = startup_tries_reg;
        precharge_count_next = precharge_count_reg;
        enable_phase_next    = enable_phase_reg;
        enable_tries_next    = enable_tries_reg;
        fault_bits_next      = fault_bits_reg;
        reply_word_next      = tick.data.reply_valid ? tick.data.reply_value : reply_word_reg;

        out_next = '0;

        unique case (main_mode_reg)
            M_STARTUP:
            begin
                out_next.led_pattern = LED_STARTUP;
                unique case (startup_phase_reg)
                    SP_CHECK_VOLTAGE:
                    begin
                        if (tick.data.bus_voltage != 16'd0)
                        begin
                            startup_phase_next = SP_PRECHARGE;
                            startup_tries_next = '0;
                        end
                        else
                        begin
                            startup_tries_next = startup_tries_reg + 9'd1;
                        end
                    end
                    SP_PRECHARGE:
                    begin
                        if (precharge_count_reg < precharge_ticks_reg)
                        begin
                            precharge_count_next = precharge_count_reg + 8'd1;
                        end
                        else
                        begin
                            precharge_count_next       = '0;
                            out_next.clear_error_pulse = 1'b1;
                            out_next.read_error_req    = 1'b1;
                            reply_word_next            = REPLY_NONE;
                            startup_phase_next         = SP_READ_ERROR;
                        end
                    end
                    SP_READ_ERROR:
                    begin
                        if (reply_word_next != REPLY_NONE)
                        begin
                            startup_phase_next = SP_CHECK_FAULT;
                            startup_tries_next = '0;
                        end
                        else
                        begin
                            out_next.read_error_req = 1'b1;
                            startup_tries_next      = startup_tries_reg + 9'd1;
                        end
                    end
                    SP_CHECK_FAULT:
                    begin
                        if (!tick.data.inverter_faulted)
                        begin
                            startup_tries_next       = '0;
                            startup_phase_next       = SP_CHECK_VOLTAGE;
                            out_next.contactor_close = 1'b1;
                            main_mode_next           = M_CHARGED;
                        end
                        else
                        begin
                            startup_tries_next = startup_tries_reg + 9'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                // Time out: flag the error of the phase that stalled
                if (startup_tries_next > {1'b0, retry_limit_reg})
                begin
                    fault_bits_next[{1'b0, startup_phase_next}] = 1'b1;
                    startup_tries_next = '0;
                    startup_phase_next = SP_CHECK_VOLTAGE;
                    main_mode_next     = M_ERROR;
                end
            end
            M_CHARGED:
            begin
                out_next.led_pattern = LED_CHARGED;
                priority if (vdc_low)
                begin
                    out_next.inverter_off = 1'b1;
                    main_mode_next        = M_STARTUP;
                end
                else if (tick.data.contactor_open_seen)
                begin
                    fault_bits_next[ERR_CONTACTOR] = 1'b1;
                    main_mode_next                 = M_ERROR;
                end
                else if (tick.data.drive_switch)
                begin
                    main_mode_next = M_ENABLE;
                end
            end
            M_ENABLE:
            begin
                out_next.led_pattern = LED_ENABLE;
                priority if (vdc_low)
                begin
                    out_next.inverter_off = 1'b1;
                    main_mode_next        = M_STARTUP;
                end
                else if (!tick.data.drive_switch)
                begin
                    out_next.inverter_off    = 1'b1;
                    out_next.contactor_close = 1'b1;
                    main_mode_next           = M_CHARGED;
                end
                else
                begin
                    unique case (enable_phase_reg)
                        EP_TURN_ON:
                        begin
                            out_next.drive_enable_cmd = 1'b1;
                            if (tick.data.inverter_ready_pin)
                            begin
                                enable_phase_next          = EP_READ_ERROR;
                                enable_tries_next          = 8'd1;
                                out_next.clear_error_pulse = 1'b1;
                                out_next.read_error_req    = 1'b1;
                                reply_word_next            = REPLY_NONE;
                            end
                            else
                            begin
                                enable_tries_next = enable_tries_reg + 8'd1;
                            end
                        end
                        EP_READ_ERROR:
                        begin
                            if (reply_word_next != REPLY_NONE)
                            begin
                                enable_phase_next = EP_CHECK_FAULT;
                                enable_tries_next = '0;
                            end
                            else
                            begin
                                out_next.read_error_req = 1'b1;
                                enable_tries_next       = enable_tries_reg + 8'd1;
                            end
                        end
                        default:
                        begin
                            if (!tick.data.inverter_faulted)
                            begin
                                enable_phase_next = EP_TURN_ON;
                                main_mode_next    = M_READY;
                            end
                            else
                            begin
                                fault_bits_next[ERR_INV_INTERNAL] = 1'b1;
                                main_mode_next                    = M_ERROR;
                            end
                        end
                    endcase
                    // Time out: flag the error of the phase that stalled
                    if (enable_tries_next == retry_limit_reg)
                    begin
                        if (enable_phase_next == EP_TURN_ON)
                        begin
                            fault_bits_next[ERR_FRG] = 1'b1;
                        end
                        else if (enable_phase_next == EP_READ_ERROR)
                        begin
                            fault_bits_next[ERR_INV_COM] = 1'b1;
                        end
                        enable_tries_next = '0;
                        enable_phase_next = EP_TURN_ON;
                        main_mode_next    = M_ERROR;
                    end
                end
            end
            M_READY:
            begin
                out_next.led_pattern = LED_READY;
                priority if (vdc_low)
                begin
                    out_next.inverter_off = 1'b1;
                    main_mode_next        = M_STARTUP;
                end
                else if (!tick.data.drive_switch)
                begin
                    out_next.inverter_off    = 1'b1;
                    out_next.contactor_close = 1'b1;
                    main_mode_next           = M_CHARGED;
                end
                else
                begin
                    // Negative regen torque overrides the pedal request
                    out_next.torque_command = tick.data.regen_torque[15] ?
                                              tick.data.regen_torque :
                                              tick.data.torque_request;
                    out_next.torque_valid   = 1'b1;
                end
            end
            M_ERROR:
            begin
                out_next.led_pattern  = LED_ERROR;
                out_next.inverter_off = 1'b1;
                out_next.torque_valid = 1'b1;
                if (tick.data.reboot_request)
                begin
                    fault_bits_next = '0;
                    reply_word_next = '0;
                    main_mode_next  = M_STARTUP;
                end
            end
            default:
            begin
                out_next.led_pattern = LED_NONE;
                main_mode_next       = M_ERROR;
            end
        endcase

        out_next.main_mode  = main_mode_next;
        out_next.error_bits = fault_bits_next;
    end

    // Hold configuration; take writes to known indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg     <= RETRY_LIMIT_RESET;
            precharge_ticks_reg <= PRECHARGE_TICKS_RESET;
            min_bus_voltage_reg <= MIN_BUS_VOLTAGE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_RETRY_LIMIT:     retry_limit_reg     <= cfg.data[7:0];
                CFG_PRECHARGE_TICKS: precharge_ticks_reg <= cfg.data[7:0];
                CFG_MIN_BUS_VOLTAGE: min_bus_voltage_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Advance sequencer state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_mode_reg       <= M_STARTUP;
            startup_phase_reg   <= SP_CHECK_VOLTAGE;
            startup_tries_reg   <= '0;
            precharge_count_reg <= '0;
            enable_phase_reg    <= EP_TURN_ON;
            enable_tries_reg    <= '0;
            fault_bits_reg      <= '0;
            reply_word_reg      <= '0;
        end
        else if (tick_fire)
        begin
            main_mode_reg       <= main_mode_next;
            startup_phase_reg   <= startup_phase_next;
            startup_tries_reg   <= startup_tries_next;
            precharge_count_reg <= precharge_count_next;
            enable_phase_reg    <= enable_phase_next;
            enable_tries_reg    <= enable_tries_next;
            fault_bits_reg      <= fault_bits_next;
            reply_word_reg      <= reply_word_next;
        end
    end

    // Hold the result word until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            out_data_reg <= out_next;
        end
    end

endmodule
